FILE: sv/vision_frame_sync_parser_macros.svh
// assertion macros shared by the frame sync parser modules
`ifndef VISION_FRAME_SYNC_PARSER_MACROS_SVH
`define VISION_FRAME_SYNC_PARSER_MACROS_SVH

// same-cycle implication
`define VFSP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VFSP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/vfsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfsp_pkg
// shared constants and types of the frame sync parser: sync bytes, frame
// layout, queue entry format and operation codes
// ----------------------------------------------------------------------------
package vfsp_pkg;

   localparam int FRAME_BYTES = 28;
   localparam int LEFT_END    = 12;
   localparam int RIGHT_START = 16;
   localparam int NUM_WORDS   = 6;
   localparam int IDX_W       = $clog2(FRAME_BYTES);
   localparam int SLOT_W      = $clog2(NUM_WORDS);
   localparam int ACC_W       = 19;

   localparam logic [7:0]        SYNC_A     = 8'd85;
   localparam logic [7:0]        SYNC_B     = 8'd170;
   localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(FRAME_BYTES - 1);
   localparam logic [IDX_W-1:0]  LEFT_LIM   = IDX_W'(LEFT_END);
   localparam logic [IDX_W-1:0]  RIGHT_LIM  = IDX_W'(RIGHT_START);
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(NUM_WORDS - 1);

   typedef enum logic [2:0] {
      OP_FAIL,
      OP_LOW,
      OP_LEFT,
      OP_RIGHT,
      OP_LAST
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [7:0]          data;
      logic [SLOT_W-1:0]   slot;
   } entry_type;

endpackage

FILE: sv/vfsp_front.sv
`timescale 1ns / 1ps
`include "vision_frame_sync_parser_macros.svh"
// ----------------------------------------------------------------------------
// vfsp_front
// accepts received bytes, tracks the sync sequence and the capture position,
// and turns each byte into at most one queue operation for the back end
// ----------------------------------------------------------------------------
module vfsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_rx_byte,
   input  logic                q_full,
   output logic                push_valid,
   output vfsp_pkg::entry_type push_entry
);
   import vfsp_pkg::*;

   typedef enum logic [2:0] {
      ST_SYNC0,
      ST_SYNC1,
      ST_SYNC2,
      ST_SYNC3,
      ST_CAPT
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             accept;
   logic             push;
   entry_type        entry;

   assign req_ready  = !q_full;
   assign accept     = req_valid && !q_full;
   assign push_valid = push;
   assign push_entry = entry;

   always_comb begin
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      push       = 1'b0;
      entry.op   = OP_FAIL;
      entry.data = req_rx_byte;
      entry.slot = idx_ff[SLOT_W:1];
      if (accept) begin
         unique case (phase_ff)
            ST_SYNC0, ST_SYNC2: begin
               if (req_rx_byte == SYNC_A) begin
                  phase_in = (phase_ff == ST_SYNC0) ? ST_SYNC1 : ST_SYNC3;
               end else begin
                  phase_in = ST_SYNC0;
                  push     = 1'b1;
               end
               idx_in = '0;
            end
            ST_SYNC1, ST_SYNC3: begin
               if (req_rx_byte == SYNC_B) begin
                  phase_in = (phase_ff == ST_SYNC1) ? ST_SYNC2 : ST_CAPT;
               end else begin
                  phase_in = ST_SYNC0;
                  push     = 1'b1;
               end
               idx_in = '0;
            end
            ST_CAPT: begin
               if (idx_ff == LAST_IDX) begin
                  entry.op = OP_LAST;
                  push     = 1'b1;
                  phase_in = ST_SYNC0;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  if (idx_ff < LEFT_LIM || idx_ff >= RIGHT_LIM) begin
                     push = 1'b1;
                     if (!idx_ff[0]) begin
                        entry.op = OP_LOW;
                     end else if (idx_ff < LEFT_LIM) begin
                        entry.op = OP_LEFT;
                     end else begin
                        entry.op = OP_RIGHT;
                     end
                  end
               end
            end
            default: begin
               phase_in = ST_SYNC0;
               idx_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ST_SYNC0;
         idx_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
   end

   `VFSP_ASSERT_IMP(a_idx_only_in_capture, clock, reset, phase_ff != ST_CAPT, idx_ff == '0, "capture index moved outside capture")
   `VFSP_ASSERT_IMP(a_idx_in_frame, clock, reset, 1'b1, idx_ff <= LAST_IDX, "capture index beyond frame end")

endmodule

FILE: sv/vfsp_queue.sv
`timescale 1ns / 1ps
`include "vision_frame_sync_parser_macros.svh"
// ----------------------------------------------------------------------------
// vfsp_queue
// two-entry queue of operations between the front and the back end
// ----------------------------------------------------------------------------
module vfsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  vfsp_pkg::entry_type push_entry,
   output logic                q_full,
   output logic                q_valid,
   input  logic                q_ready,
   output vfsp_pkg::entry_type q_entry
);
   import vfsp_pkg::*;

   entry_type  entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign q_full  = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_entry = entry_ff[rd_ptr_ff];
   assign pop     = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push_valid ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `VFSP_ASSERT_IMP(a_no_push_when_full, clock, reset, push_valid, count_ff != 2'd2, "push into full queue")

endmodule

FILE: sv/vfsp_back.sv
`timescale 1ns / 1ps
`include "vision_frame_sync_parser_macros.svh"
// ----------------------------------------------------------------------------
// vfsp_back
// assembles left and right words, keeps running checksums and the failure
// count, and registers one result per ended attempt
// ----------------------------------------------------------------------------
module vfsp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  vfsp_pkg::entry_type q_entry,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_frame_ok,
   output logic                rsp_right_sum_ok,
   output logic                rsp_block_present,
   output logic [7:0]          rsp_fail_count,
   output logic [15:0]         rsp_avg_checksum,
   output logic [15:0]         rsp_avg_signature,
   output logic [15:0]         rsp_avg_x,
   output logic [15:0]         rsp_avg_y,
   output logic [15:0]         rsp_avg_width,
   output logic [15:0]         rsp_avg_height
);
   import vfsp_pkg::*;

   logic [15:0]      left_words_ff [NUM_WORDS];
   logic [15:0]      left_words_in [NUM_WORDS];
   logic [15:0]      right_words_ff [NUM_WORDS];
   logic [15:0]      right_words_in [NUM_WORDS];
   logic [7:0]       hold_ff, hold_in;
   logic [ACC_W-1:0] left_acc_ff, left_acc_in;
   logic [ACC_W-1:0] right_acc_ff, right_acc_in;
   logic [7:0]       failures_ff, failures_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             frame_ok_ff, right_ok_ff, present_ff;
   logic [7:0]       fail_count_ff;
   logic [15:0]      avg_ff [NUM_WORDS];
   logic [15:0]      avg_in [NUM_WORDS];
   logic [16:0]      pair_sum [NUM_WORDS];

   logic             is_result;
   logic             pop;
   logic             load;
   logic [15:0]      word;
   logic [ACC_W-1:0] right_total;
   logic             left_ok;
   logic             right_ok;
   logic             frame_ok;

   assign is_result   = (q_entry.op == OP_FAIL) || (q_entry.op == OP_LAST);
   assign q_ready     = !is_result || !rsp_valid_ff || rsp_ready;
   assign pop         = q_valid && q_ready;
   assign load        = pop && is_result;
   assign word        = {q_entry.data, hold_ff};
   assign right_total = right_acc_ff + ACC_W'(word);
   assign left_ok     = (left_acc_ff == ACC_W'(left_words_ff[0]));
   assign right_ok    = (right_total == ACC_W'(right_words_ff[0]));

   always_comb begin
      left_words_in  = left_words_ff;
      right_words_in = right_words_ff;
      hold_in        = hold_ff;
      left_acc_in    = left_acc_ff;
      right_acc_in   = right_acc_ff;
      frame_ok       = 1'b0;
      if (pop) begin
         unique case (q_entry.op)
            OP_LOW: begin
               hold_in = q_entry.data;
            end
            OP_LEFT: begin
               left_words_in[q_entry.slot] = word;
               if (q_entry.slot != '0) begin
                  left_acc_in = left_acc_ff + ACC_W'(word);
               end
            end
            OP_RIGHT: begin
               right_words_in[q_entry.slot] = word;
               if (q_entry.slot != '0) begin
                  right_acc_in = right_acc_ff + ACC_W'(word);
               end
            end
            OP_LAST: begin
               right_words_in[LAST_SLOT] = word;
               left_acc_in  = '0;
               right_acc_in = '0;
               frame_ok     = left_ok;
            end
            default: begin
               frame_ok = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      failures_in = failures_ff;
      if (load) begin
         if (frame_ok) begin
            failures_in = '0;
         end else if (failures_ff != 8'hFF) begin
            failures_in = failures_ff + 8'd1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_WORDS; i++) begin
         pair_sum[i] = {1'b0, left_words_in[i]} + {1'b0, right_words_in[i]};
         avg_in[i]   = pair_sum[i][16:1];
      end
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            left_words_ff[i]  <= '0;
            right_words_ff[i] <= '0;
         end
         hold_ff      <= '0;
         left_acc_ff  <= '0;
         right_acc_ff <= '0;
         failures_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         left_words_ff  <= left_words_in;
         right_words_ff <= right_words_in;
         hold_ff        <= hold_in;
         left_acc_ff    <= left_acc_in;
         right_acc_ff   <= right_acc_in;
         failures_ff    <= failures_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ok_ff   <= frame_ok;
         right_ok_ff   <= frame_ok && right_ok;
         present_ff    <= (failures_in <= 8'd1);
         fail_count_ff <= failures_in;
         avg_ff        <= avg_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_ok      = frame_ok_ff;
   assign rsp_right_sum_ok  = right_ok_ff;
   assign rsp_block_present = present_ff;
   assign rsp_fail_count    = fail_count_ff;
   assign rsp_avg_checksum  = avg_ff[0];
   assign rsp_avg_signature = avg_ff[1];
   assign rsp_avg_x         = avg_ff[2];
   assign rsp_avg_y         = avg_ff[3];
   assign rsp_avg_width     = avg_ff[4];
   assign rsp_avg_height    = avg_ff[5];

   `VFSP_ASSERT_NXT(a_good_frame_clears, clock, reset, load && frame_ok, failures_ff == '0, "good frame did not clear failures")
   `VFSP_ASSERT_IMP(a_count_tracks, clock, reset, rsp_valid_ff, fail_count_ff == failures_ff, "reported count differs from failure count")
   `VFSP_ASSERT_IMP(a_present_flag, clock, reset, rsp_valid_ff, present_ff == (fail_count_ff <= 8'd1), "presence flag inconsistent with count")

endmodule

FILE: sv/vision_frame_sync_parser.sv
`timescale 1ns / 1ps
// an ending byte's result passes the queue and then the result register to rsp_valid
// one byte per cycle while the queue has room; each byte is one queue op or none
// the rate is set by the two-entry queue and the single result register
// a waiting result stalls the next result entry, and the front once the queue fills
// reset clears sync state, capture position, stored words, checksums and failure count
// ----------------------------------------------------------------------------
// vision_frame_sync_parser
// sync word frame parser with additive checksum and left/right averaging
// ----------------------------------------------------------------------------
module vision_frame_sync_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_frame_ok,
   output logic        rsp_right_sum_ok,
   output logic        rsp_block_present,
   output logic [7:0]  rsp_fail_count,
   output logic [15:0] rsp_avg_checksum,
   output logic [15:0] rsp_avg_signature,
   output logic [15:0] rsp_avg_x,
   output logic [15:0] rsp_avg_y,
   output logic [15:0] rsp_avg_width,
   output logic [15:0] rsp_avg_height
);
   import vfsp_pkg::*;

   logic      push_valid;
   entry_type push_entry;
   logic      q_full;
   logic      q_valid;
   logic      q_ready;
   entry_type q_entry;

   vfsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   vfsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_entry    (q_entry)
   );

   vfsp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_ready           (q_ready),
      .q_entry           (q_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_ok      (rsp_frame_ok),
      .rsp_right_sum_ok  (rsp_right_sum_ok),
      .rsp_block_present (rsp_block_present),
      .rsp_fail_count    (rsp_fail_count),
      .rsp_avg_checksum  (rsp_avg_checksum),
      .rsp_avg_signature (rsp_avg_signature),
      .rsp_avg_x         (rsp_avg_x),
      .rsp_avg_y         (rsp_avg_y),
      .rsp_avg_width     (rsp_avg_width),
      .rsp_avg_height    (rsp_avg_height)
   );

endmodule
